FILE: rtl/mor_pkg.sv
// Shared types and constants for the maximal ones rectangle block.
package mor_pkg;

  // Default sizes for the top-level parameters
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  // Row width register
  localparam int ROW_WIDTH_W = 9;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 9'd256;

  // Area result and its saturation ceiling
  localparam int AREA_W = 17;
  localparam logic [AREA_W-1:0] AREA_LIMIT = 17'h1FFFF;

  // Input word: one matrix cell
  typedef struct packed {
    logic cell_req;
    logic last_cell;
  } in_word_t;

  // Output word: one matrix result
  typedef struct packed {
    logic [AREA_W-1:0] max_area;
    logic              row_overflow;
  } out_word_t;

  // Control from the sequencer to the best-area tracker
  typedef struct packed {
    logic clear;
    logic load;
  } area_ctl_t;

endpackage

FILE: rtl/maximal_ones_rectangle_top.sv
// Maximal all-ones rectangle finder: top level with sequencer and memories.
//
// Cells arrive one word at a time in row-major order; row_width sets the
// columns per row (0 acts as 1, values above MAX_COLS act as MAX_COLS). Column
// heights live in a one-port-read RAM and a monotonic stack of (height, column)
// lives in a second RAM. A cell that does not close a row is accepted, then its
// column height gets a read-modify-write. A cell that closes a row of n columns
// adds a stack pass: for each column (and once past the last) the height read,
// latch and compare/push states, and for each pop the stack read below the top
// and the area update; the registered read of the two RAMs sets these steps. The
// word carrying last_cell then passes a post state that loads the result into
// the output register once it is free, where it waits. Heights are cleared
// between matrices by a fill count, so no clearing pass is needed after reset or
// after a result.
module maximal_ones_rectangle_top import mor_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_we,
  input  logic [ROW_WIDTH_W-1:0] cfg_wdata
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NW = $clog2(MAX_COLS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int SW = HW + CW;
  localparam int WW = (NW > ROW_WIDTH_W) ? NW : ROW_WIDTH_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CELL = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CUR  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_POP  = 3'd5;
  localparam logic [2:0] ST_AREA = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]             state;
  logic [ROW_WIDTH_W-1:0] row_width;
  logic [CW-1:0]          column_index;
  logic [CW-1:0]          col;
  logic [NW-1:0]          fill;
  logic [NW-1:0]          n_cols;
  logic [NW-1:0]          idx;
  logic [NW-1:0]          depth;
  logic                   cell_filled;
  logic                   cell_last;
  logic                   overflow_seen;
  logic [HW-1:0]          cur;
  logic [HW-1:0]          top_h;
  logic [HW-1:0]          bar_h;
  logic [NW-1:0]          bar_w;

  logic [WW-1:0]          rw_ext;
  logic [NW-1:0]          w_eff;
  logic [CW-1:0]          col_sel;
  logic [HW-1:0]          old_h;
  logic [HW-1:0]          new_h;
  logic                   sat_hit;
  logic                   row_end;
  logic                   pop;
  logic [NW-1:0]          left;

  logic                   h_we;
  logic [CW-1:0]          h_raddr;
  logic [HW-1:0]          h_rdata;
  logic                   s_we;
  logic [SW-1:0]          s_rdata;
  logic [HW-1:0]          s_h;
  logic [CW-1:0]          s_idx;
  area_ctl_t              area_ctl;
  logic [AREA_W-1:0]      best;

  // Row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  // Effective width and the column this cell lands in
  assign rw_ext = WW'(row_width);
  always_comb begin
    if (rw_ext == '0) begin
      w_eff = NW'(1);
    end else if (rw_ext > WW'(MAX_COLS)) begin
      w_eff = NW'(MAX_COLS);
    end else begin
      w_eff = NW'(rw_ext);
    end
    if (NW'(column_index) >= w_eff) begin
      col_sel = CW'(w_eff - NW'(1));
    end else begin
      col_sel = column_index;
    end
  end

  // Height update; columns at or past the fill count read as zero
  always_comb begin
    old_h   = (NW'(col) < fill) ? h_rdata : '0;
    sat_hit = cell_filled && (old_h >= HW'(MAX_ROWS));
    if (!cell_filled) begin
      new_h = '0;
    end else if (sat_hit) begin
      new_h = HW'(MAX_ROWS);
    end else begin
      new_h = old_h + HW'(1);
    end
    row_end = ((NW'(col) + NW'(1)) >= w_eff) || cell_last;
  end

  // Stack compare and left edge of the popped bar
  assign s_h   = s_rdata[SW-1:CW];
  assign s_idx = s_rdata[CW-1:0];
  assign pop   = (depth != '0) && (top_h >= cur);
  assign left  = (depth > NW'(1)) ? (NW'(s_idx) + NW'(1)) : '0;

  assign in_ready = (state == ST_IDLE);
  assign h_we     = (state == ST_CELL);
  assign h_raddr  = (state == ST_RD) ? CW'(idx) : col_sel;
  assign s_we     = (state == ST_CMP) && !pop && (idx < n_cols);

  always_comb begin
    area_ctl.load  = (state == ST_AREA);
    area_ctl.clear = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  // Column heights
  mor_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_COLS)
  ) u_heights (
    .clk   (clk),
    .we    (h_we),
    .waddr (col),
    .wdata (new_h),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Bar stack: height and column of each entry
  mor_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (CW'(depth)),
    .wdata ({cur, CW'(idx)}),
    .raddr (CW'(depth - NW'(2))),
    .rdata (s_rdata)
  );

  mor_area #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_area (
    .clk   (clk),
    .rst   (rst),
    .ctl   (area_ctl),
    .bar_h (bar_h),
    .bar_w (bar_w),
    .best  (best)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      column_index  <= '0;
      fill          <= '0;
      depth         <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // result word taken; the post state reloads it on its own
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            col         <= col_sel;
            cell_filled <= in_data.cell_req;
            cell_last   <= in_data.last_cell;
            state       <= ST_CELL;
          end
        end
        ST_CELL: begin
          if (NW'(col) == fill) begin
            fill <= fill + NW'(1);
          end
          if (sat_hit) begin
            overflow_seen <= 1'b1;
          end
          if (row_end) begin
            n_cols <= NW'(col) + NW'(1);
            idx    <= '0;
            depth  <= '0;
            state  <= ST_RD;
          end else begin
            column_index <= col + CW'(1);
            state        <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_CUR;
        end
        ST_CUR: begin
          cur   <= (idx < n_cols) ? h_rdata : '0;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (pop) begin
            state <= ST_POP;
          end else begin
            if (idx < n_cols) begin
              top_h <= cur;
              depth <= depth + NW'(1);
            end
            if (idx == n_cols) begin
              column_index <= '0;
              state        <= cell_last ? ST_EMIT : ST_IDLE;
            end else begin
              idx   <= idx + NW'(1);
              state <= ST_RD;
            end
          end
        end
        ST_POP: begin
          bar_h <= top_h;
          bar_w <= idx - left;
          depth <= depth - NW'(1);
          if (depth > NW'(1)) begin
            top_h <= s_h;
          end
          state <= ST_AREA;
        end
        ST_AREA: begin
          state <= ST_CMP;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.max_area      <= best;
            out_data.row_overflow  <= overflow_seen;
            fill                   <= '0;
            overflow_seen          <= 1'b0;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Written columns always form a prefix, so a cell never skips past the fill count
  a_col_in_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CELL) |-> (NW'(col) <= fill))
    else $error("cell column beyond fill count");

  // Stack never holds more bars than columns scanned
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (depth <= idx))
    else $error("stack deeper than scanned columns");

  // Posting a result clears the matrix and leaves a valid word
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && (!out_valid || out_ready)) |=>
      ((fill == '0) && out_valid && (best == '0)))
    else $error("result posted without clearing matrix state");
`endif

endmodule

FILE: rtl/mor_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mor_area.sv
// Best-area tracker: bar height times width, saturated, kept as a running max.
module mor_area import mor_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  localparam int NW = $clog2(MAX_COLS + 1),
  localparam int HW = $clog2(MAX_ROWS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  area_ctl_t         ctl,
  input  logic [HW-1:0]     bar_h,
  input  logic [NW-1:0]     bar_w,
  output logic [AREA_W-1:0] best
);

  localparam int PW = HW + NW;
  localparam int EW = (PW > AREA_W) ? PW : AREA_W;

  logic [PW-1:0]     prod;
  logic [EW-1:0]     prod_ext;
  logic [AREA_W-1:0] area_sat;

  // Candidate area, clipped at the area ceiling
  assign prod     = {{NW{1'b0}}, bar_h} * {{HW{1'b0}}, bar_w};
  assign prod_ext = EW'(prod);
  assign area_sat = (prod_ext > EW'(AREA_LIMIT)) ? AREA_LIMIT : AREA_W'(prod_ext);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best <= '0;
    end else if (ctl.load && (area_sat > best)) begin
      best <= area_sat;
    end
  end

endmodule

FILE: dv/tb.sv
// Testbench for the maximal ones rectangle block: directed table, random matrices, scoreboard.
module tb;
  import mor_pkg::*;

  localparam int COLS          = DEF_MAX_COLS;
  localparam int ROWS          = DEF_MAX_ROWS;
  localparam int SETTLE_CYCLES = 6 * COLS + 3 + 16;  // longest row scan plus margin
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int RAND_WORDS    = 450;  // saturation and random words together
  localparam int RAND_RESULTS  = 12;
  localparam int PLAN_LEN      = 26;

  typedef enum logic {STEP_CELL, STEP_WIDTH} step_kind_e;

  // One row of the directed table; a typed result is used where one is given
  typedef struct packed {
    step_kind_e        kind;
    logic              filled;
    logic              last;
    logic [8:0]        width;
    logic              typed;
    logic [AREA_W-1:0] area;
    logic              ovf;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_word_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_word_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [ROW_WIDTH_W-1:0] cfg_wdata = '0;

  // Predictor state
  bit [8:0]  col_height [COLS];
  bit [8:0]  width_reg = ROW_WIDTH_RESET;
  int        cur_col;
  int        best;
  bit        ovf_seen;

  out_word_t pending_areas [$];
  int        errors;
  int        cycles;
  int        words_in;
  int        results_seen;
  int        width_writes;
  int        rand_words;
  int        rand_results;
  int        sat_results;
  bit        tx_steady;
  bit        rx_steady;
  int        rx_hold;

  plan_row_t plan [PLAN_LEN] = '{
    '{STEP_CELL,  1'b1, 1'b1, 9'd0,   1'b1, 17'd1, 1'b0},  // single cell after reset
    '{STEP_CELL,  1'b0, 1'b1, 9'd0,   1'b1, 17'd0, 1'b0},  // single empty cell
    '{STEP_WIDTH, 1'b0, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},  // zero width acts as one
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b1, 9'd0,   1'b1, 17'd3, 1'b0},
    '{STEP_WIDTH, 1'b0, 1'b0, 9'd511, 1'b0, 17'd0, 1'b0},  // above range, clamps
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b0, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b1, 9'd0,   1'b1, 17'd2, 1'b0},  // last cell mid-row
    '{STEP_WIDTH, 1'b0, 1'b0, 9'd2,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b0, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b1, 9'd0,   1'b1, 17'd3, 1'b0},
    '{STEP_WIDTH, 1'b0, 1'b0, 9'd256, 1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_WIDTH, 1'b0, 1'b0, 9'd3,   1'b0, 17'd0, 1'b0},  // shrink width mid-row
    '{STEP_CELL,  1'b1, 1'b0, 9'd0,   1'b0, 17'd0, 1'b0},
    '{STEP_CELL,  1'b0, 1'b1, 9'd0,   1'b0, 17'd0, 1'b0}
  };

  maximal_ones_rectangle_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly no gap, some short gaps, a few long ones
  function automatic int idle_len(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_matrix();
    foreach (col_height[i]) col_height[i] = '0;
    cur_col  = 0;
    best     = 0;
    ovf_seen = 1'b0;
  endfunction

  // Largest rectangle under the histogram of columns 0..n-1
  function automatic void scan_histogram(int n);
    int     stk [$];
    int     cur;
    int     top;
    int     left;
    longint a;
    for (int i = 0; i <= n; i++) begin
      cur = (i < n) ? int'(col_height[i]) : 0;
      while (stk.size() > 0 && int'(col_height[stk[$]]) >= cur) begin
        top  = stk.pop_back();
        left = (stk.size() > 0) ? stk[$] + 1 : 0;
        a    = longint'(col_height[top]) * longint'(i - left);
        if (a > longint'(AREA_LIMIT)) a = longint'(AREA_LIMIT);
        if (a > longint'(best)) best = int'(a);
      end
      if (i < n) stk.push_back(i);
    end
  endfunction

  // Advance the predicted state by one cell; returns 1 when a result is due
  function automatic bit rect_step(input logic filled, input logic last, output out_word_t res);
    int w;
    int col;
    w   = (width_reg == 0) ? 1 : ((int'(width_reg) > COLS) ? COLS : int'(width_reg));
    col = (cur_col >= w) ? w - 1 : cur_col;
    res = '0;
    if (filled) begin
      if (int'(col_height[col]) >= ROWS) begin
        col_height[col] = 9'(ROWS);
        ovf_seen        = 1'b1;
      end else begin
        col_height[col] = col_height[col] + 9'd1;
      end
    end else begin
      col_height[col] = '0;
    end
    if (col + 1 >= w || last) begin
      scan_histogram(col + 1);
      cur_col = 0;
    end else begin
      cur_col = col + 1;
    end
    if (!last) return 1'b0;
    res.max_area     = best[AREA_W-1:0];
    res.row_overflow = ovf_seen;
    clear_matrix();
    return 1'b1;
  endfunction

  // Send one cell word; starts and ends on a falling edge
  task automatic push_word(input logic filled, input logic last, input bit fixed,
                           input out_word_t fixed_res);
    int        g;
    out_word_t res;
    g = idle_len(tx_steady);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cell_req: filled, last_cell: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_in++;
    if (rect_step(filled, last, res)) pending_areas.push_back(fixed ? fixed_res : res);
    @(negedge clk);
  endtask

  // Drain every pending result, then let a full row scan finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_areas.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input logic [8:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    width_reg = v;
    width_writes++;
  endtask

  // One random phase: a width setting, a few matrices, maybe a dangling partial row
  task automatic run_phase();
    int         r;
    int         eff;
    int         total;
    int         density;
    logic [8:0] w;
    r = $urandom_range(0, 11);
    case (r)
      0: w = 9'd0;
      1: w = 9'd1;
      2: w = 9'd256;
      3: w = 9'($urandom_range(257, 511));
      4: w = 9'($urandom_range(17, 255));
      default: w = 9'($urandom_range(2, 9));
    endcase
    write_width(w);
    eff = (w == 0) ? 1 : ((int'(w) > COLS) ? COLS : int'(w));
    tx_steady = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 4)) begin
      // sender holds off until the block has delivered everything
      if ($urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        while (pending_areas.size() != 0) @(negedge clk);
      end
      case ($urandom_range(0, 2))
        0: density = 50;
        1: density = 85;
        default: density = 15;
      endcase
      if (eff <= 16) begin
        total = $urandom_range(1, 4) * eff;
        if ($urandom_range(0, 3) == 0) total -= $urandom_range(0, eff - 1);
      end else begin
        total = $urandom_range(1, 24);
      end
      for (int k = 0; k < total; k++) begin
        push_word($urandom_range(0, 99) < density, k == total - 1, 1'b0, '0);
        rand_words++;
      end
      rand_results++;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        push_word(1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
        rand_words++;
      end
    end
  endtask

  // Receiver: random backpressure, occasionally switching to always-ready
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      rx_hold = idle_len(rx_steady);
    end
  end

  // Scoreboard: compare each result word with the oldest pending one
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_areas.size() == 0) begin
        $error("result word with nothing pending: max_area %0d row_overflow %0b",
               out_data.max_area, out_data.row_overflow);
        errors++;
      end else begin
        want = pending_areas.pop_front();
        results_seen++;
        if (out_data.max_area !== want.max_area) begin
          $error("max_area: expected %0d, got %0d", want.max_area, out_data.max_area);
          errors++;
        end
        if (out_data.row_overflow !== want.row_overflow) begin
          $error("row_overflow: expected %0b, got %0b", want.row_overflow,
                 out_data.row_overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int        n;
    out_word_t typed_res;
    clear_matrix();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WIDTH) begin
        write_width(plan[i].width);
      end else begin
        typed_res.max_area     = plan[i].area;
        typed_res.row_overflow = plan[i].ovf;
        push_word(plan[i].filled, plan[i].last, plan[i].typed, typed_res);
      end
    end

    // Height saturation: one tall column of ones at width one
    write_width(9'd1);
    tx_steady = 1'b0;
    n = $urandom_range(ROWS + 1, ROWS + 6);
    for (int k = 0; k < n; k++) begin
      push_word(1'b1, k == n - 1, 1'b0, '0);
      rand_words++;
    end
    sat_results++;

    // Random matrices
    while (rand_words < RAND_WORDS || rand_results < RAND_RESULTS) run_phase();

    wait_idle();
    $display("Covered %0d cell words, %0d results checked, %0d row width writes,",
             words_in, results_seen, width_writes);
    $display("including clamped widths, mid-row width changes and %0d saturating matrix",
             sat_results);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
